>>> design/dkeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkeq_pkg
// Shared types and constants of the deferred key event queue.
// ----------------------------------------------------------------------------
package dkeq_pkg;

   localparam int QUEUE_DEPTH = 16;

   localparam logic [7:0] ACT_PRESS   = 8'd0;
   localparam logic [7:0] ACT_RELEASE = 8'd1;
   localparam logic [7:0] ACT_TAP     = 8'd2;

   localparam logic CMD_KEY_PRESS   = 1'b0;
   localparam logic CMD_KEY_RELEASE = 1'b1;

   typedef enum logic {
      CMD_PUSH,
      CMD_DRAIN
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [7:0]  action;
      logic [15:0] keycode;
   } event_type;

   typedef struct packed {
      cmd_kind_type kind;
      event_type    ev;
   } cmd_type;

   typedef struct packed {
      logic        command;
      logic [15:0] key;
      logic [7:0]  source_index;
      logic        last;
   } rsp_type;

endpackage

>>> design/deferred_key_event_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deferred_key_event_queue_core
// Ring queue of deferred key events with push and drain commands.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; a two-entry
// command queue sits in front of the execution engine, so start is taken
// while a drain is still running and busy rises only when both entries are
// in use. The engine runs a push in its idle state, so pushes go at one per
// cycle while no drain holds it; a push into a full ring evicts the oldest
// event, given as a result only if it is a press or a release. A drain holds
// the engine in its drain and flush states, paced by the ring's single read
// port that walks one event per cycle; an empty ring's drain leaves it idle.
// Results come out one per cycle at most, each on rsp_strobe for exactly one
// cycle, cannot be stalled, and the last of a transaction carries rsp_last.
module deferred_key_event_queue_core #(
   parameter int QUEUE_DEPTH = dkeq_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [7:0]  req_index,
   input  logic [7:0]  req_action,
   input  logic [15:0] req_keycode,
   output logic        rsp_strobe,
   output logic        rsp_command,
   output logic [15:0] rsp_key,
   output logic [7:0]  rsp_source_index,
   output logic        rsp_last
);

   logic              cmd_valid;
   logic              pop;
   dkeq_pkg::cmd_type cmd;
   dkeq_pkg::rsp_type rsp;

   dkeq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_index  (req_index),
      .req_action (req_action),
      .req_keycode(req_keycode),
      .pop        (pop),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   dkeq_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop),
      .rsp_strobe(rsp_strobe),
      .rsp       (rsp)
   );

   assign rsp_command      = rsp.command;
   assign rsp_key          = rsp.key;
   assign rsp_source_index = rsp.source_index;
   assign rsp_last         = rsp.last;

endmodule

>>> design/dkeq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkeq_ram
// Generic single write, single read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module dkeq_ram #(
   parameter int WIDTH = $bits(dkeq_pkg::event_type),
   parameter int DEPTH = dkeq_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/dkeq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkeq_front
// Accepts transactions, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dkeq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [7:0]        req_index,
   input  logic [7:0]        req_action,
   input  logic [15:0]       req_keycode,
   input  logic              pop,
   output logic              cmd_valid,
   output dkeq_pkg::cmd_type cmd
);

   dkeq_pkg::cmd_type slot_ff [2];
   logic              wptr_ff;
   logic              rptr_ff;
   logic [1:0]        fill_ff;
   logic              wptr_in;
   logic              rptr_in;
   logic [1:0]        fill_in;
   logic              accept;
   logic              do_pop;
   dkeq_pkg::cmd_type new_cmd;

   assign busy      = (fill_ff == 2'd2);
   assign accept    = start && !busy;
   assign cmd_valid = (fill_ff != 2'd0);
   assign do_pop    = pop && cmd_valid;
   assign cmd       = slot_ff[rptr_ff];

   always_comb begin
      new_cmd.kind       = req_op ? dkeq_pkg::CMD_DRAIN : dkeq_pkg::CMD_PUSH;
      new_cmd.ev.index   = req_index;
      new_cmd.ev.action  = req_action;
      new_cmd.ev.keycode = req_keycode;
      wptr_in = accept ? !wptr_ff : wptr_ff;
      rptr_in = do_pop ? !rptr_ff : rptr_ff;
      fill_in = fill_ff + 2'(accept) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (accept) begin
         slot_ff[wptr_ff] <= new_cmd;
      end
   end

endmodule

>>> design/dkeq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkeq_back
// Executes pushes and drains against the event ring and forms the results.
// ----------------------------------------------------------------------------
module dkeq_back #(
   parameter int QUEUE_DEPTH = dkeq_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  dkeq_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_strobe,
   output dkeq_pkg::rsp_type rsp
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
      logic [PTR_W:0] s;
      s = {1'b0, p} + (PTR_W+1)'(n);
      if (s >= (PTR_W+1)'(QUEUE_DEPTH)) begin
         s = s - (PTR_W+1)'(QUEUE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    rptr_ff, rptr_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    proc_ff, proc_in;
   logic                evict_ff, evict_in;
   dkeq_pkg::rsp_type   pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   dkeq_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                ram_we;
   logic [PTR_W-1:0]    ram_waddr;
   dkeq_pkg::event_type ram_wdata;
   logic [PTR_W-1:0]    ram_raddr;
   logic [$bits(dkeq_pkg::event_type)-1:0] ram_rdata;
   dkeq_pkg::event_type rd_ev;
   logic [PTR_W-1:0]    tail;
   logic                rd_is_press;
   logic                rd_is_release;
   logic                rd_is_tap;
   dkeq_pkg::rsp_type   rd_rsp;

   dkeq_ram #(
      .WIDTH($bits(dkeq_pkg::event_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_ev         = dkeq_pkg::event_type'(ram_rdata);
   assign tail          = ptr_add(head_ff, count_ff);
   assign rd_is_press   = (rd_ev.action == dkeq_pkg::ACT_PRESS);
   assign rd_is_release = (rd_ev.action == dkeq_pkg::ACT_RELEASE);
   assign rd_is_tap     = (rd_ev.action == dkeq_pkg::ACT_TAP);
   assign pop           = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      rd_rsp.command      = rd_is_release ? dkeq_pkg::CMD_KEY_RELEASE
                                          : dkeq_pkg::CMD_KEY_PRESS;
      rd_rsp.key          = rd_ev.keycode;
      rd_rsp.source_index = rd_ev.index;
      rd_rsp.last         = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rptr_in       = rptr_ff;
      len_in        = len_ff;
      proc_in       = proc_ff;
      evict_in      = 1'b0;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_in.last   = 1'b0;
      rsp_valid_in  = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = tail;
      ram_wdata     = cmd.ev;
      ram_raddr     = head_ff;

      // oldest entry pushed out by a push into a full ring
      if (evict_ff && (rd_is_press || rd_is_release)) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rd_rsp;
         rsp_in.last  = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == dkeq_pkg::CMD_PUSH) begin
                  // when full, tail equals head: read-first ram returns the old entry
                  ram_we = 1'b1;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     head_in  = ptr_add(head_ff, CNT_W'(1));
                     evict_in = 1'b1;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff != '0) begin
                  // new ring starts behind the old tail so taps never hit unread entries
                  rptr_in  = ptr_add(head_ff, CNT_W'(1));
                  len_in   = count_ff;
                  proc_in  = '0;
                  head_in  = tail;
                  count_in = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            ram_raddr = rptr_ff;
            rptr_in   = ptr_add(rptr_ff, CNT_W'(1));
            proc_in   = proc_ff + CNT_W'(1);
            if (rd_is_tap) begin
               ram_we            = 1'b1;
               ram_wdata.index   = rd_ev.index;
               ram_wdata.action  = dkeq_pkg::ACT_RELEASE;
               ram_wdata.keycode = rd_ev.keycode;
               count_in          = count_ff + CNT_W'(1);
            end
            // one result is held back until it is known whether it is the last
            if (rd_is_press || rd_is_release || rd_is_tap) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_in       = rd_rsp;
               pend_valid_in = 1'b1;
            end
            if (proc_in == len_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               rsp_in.last  = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         evict_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         evict_ff      <= evict_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rptr_ff <= rptr_in;
      len_ff  <= len_in;
      proc_ff <= proc_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

>>> design/dkeq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkeq_checker
// Port-level checks of the deferred key event queue, bound to the top level.
// ----------------------------------------------------------------------------
module dkeq_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // nothing is pending right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!rsp_strobe && !busy))
      else $error("result or busy right after reset");

   // a result needs a transaction taken after reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!$past(reset, 1) && !$past(reset, 2)))
      else $error("result too soon after reset");

   // the command queue fills only through accepted transactions
   assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy)
      else $error("busy rose without an accepted transaction");

endmodule

bind deferred_key_event_queue_core dkeq_checker u_dkeq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deferred key event queue core.
// Pushes and drains are driven on the command port; a tracker class keeps its
// own ring of deferred events and predicts every key command that must come
// out. Each strobed result is matched against the oldest predicted command.
// ----------------------------------------------------------------------------
module testbench;
   import dkeq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 140;
   localparam int MAX_GAP      = 12;

   class key_event_tracker;
      event_type ring[QUEUE_DEPTH];
      int        head;
      int        count;
      rsp_type   pending_commands[$];
      int        mismatch_count;

      function new();
         head = 0;
         count = 0;
         mismatch_count = 0;
      endfunction

      task report_mismatch(input string what);
         if (mismatch_count < 40) $display("MISMATCH: %s", what);
         mismatch_count++;
      endtask

      function automatic rsp_type make_command(input logic cmd, input event_type ev);
         rsp_type r;
         r.command = cmd;
         r.key = ev.keycode;
         r.source_index = ev.index;
         r.last = 1'b0;
         return r;
      endfunction

      function void append_event(input event_type ev);
         ring[(head + count) % QUEUE_DEPTH] = ev;
         count++;
      endfunction

      // work out the key commands that one accepted transaction causes
      function void note_transaction(input cmd_kind_type kind, input event_type ev);
         rsp_type   batch[$];
         rsp_type   r;
         event_type snap[QUEUE_DEPTH];
         event_type rel;
         int        len;
         if (kind == CMD_PUSH) begin
            if (count == QUEUE_DEPTH) begin
               // oldest event falls out; a tap or unknown action vanishes
               if (ring[head].action == ACT_PRESS)
                  batch.push_back(make_command(CMD_KEY_PRESS, ring[head]));
               else if (ring[head].action == ACT_RELEASE)
                  batch.push_back(make_command(CMD_KEY_RELEASE, ring[head]));
               head = (head + 1) % QUEUE_DEPTH;
               count--;
            end
            append_event(ev);
         end else begin
            len = count;
            for (int i = 0; i < len; i++) snap[i] = ring[(head + i) % QUEUE_DEPTH];
            head = 0;
            count = 0;
            for (int i = 0; i < len; i++) begin
               if (snap[i].action == ACT_PRESS) begin
                  batch.push_back(make_command(CMD_KEY_PRESS, snap[i]));
               end else if (snap[i].action == ACT_RELEASE) begin
                  batch.push_back(make_command(CMD_KEY_RELEASE, snap[i]));
               end else if (snap[i].action == ACT_TAP) begin
                  // tap leaves its release behind for the next drain
                  rel = snap[i];
                  rel.action = ACT_RELEASE;
                  append_event(rel);
                  batch.push_back(make_command(CMD_KEY_PRESS, snap[i]));
               end
            end
         end
         if (batch.size() > 0) begin
            r = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
         end
         foreach (batch[i]) pending_commands.push_back(batch[i]);
      endfunction

      task check_command(input rsp_type got);
         rsp_type want;
         if (pending_commands.size() == 0) begin
            report_mismatch($sformatf("unexpected command %0d key %h index %h last %0d",
                                      got.command, got.key, got.source_index, got.last));
         end else begin
            want = pending_commands.pop_front();
            if (got.command !== want.command)
               report_mismatch($sformatf("command got %0d want %0d (key %h)",
                                         got.command, want.command, want.key));
            if (got.key !== want.key)
               report_mismatch($sformatf("key got %h want %h", got.key, want.key));
            if (got.source_index !== want.source_index)
               report_mismatch($sformatf("source_index got %h want %h (key %h)",
                                         got.source_index, want.source_index, want.key));
            if (got.last !== want.last)
               report_mismatch($sformatf("last got %0d want %0d (key %h)",
                                         got.last, want.last, want.key));
         end
      endtask

      function int outstanding();
         return pending_commands.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = 1'b0;
   logic [7:0]  req_index = '0;
   logic [7:0]  req_action = '0;
   logic [15:0] req_keycode = '0;
   logic        rsp_strobe;
   logic        rsp_command;
   logic [15:0] rsp_key;
   logic [7:0]  rsp_source_index;
   logic        rsp_last;

   key_event_tracker tracker = new();
   int               cycle_count = 0;
   int               items_sent;
   bit               no_idle;

   deferred_key_event_queue_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_index        (req_index),
      .req_action       (req_action),
      .req_keycode      (req_keycode),
      .rsp_strobe       (rsp_strobe),
      .rsp_command      (rsp_command),
      .rsp_key          (rsp_key),
      .rsp_source_index (rsp_source_index),
      .rsp_last         (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type got;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else if (!reset && rsp_strobe) begin
         got.command = rsp_command;
         got.key = rsp_key;
         got.source_index = rsp_source_index;
         got.last = rsp_last;
         tracker.check_command(got);
      end
   end

   function automatic event_type make_event(input logic [7:0] idx, input logic [7:0] act,
                                            input logic [15:0] kc);
      event_type ev;
      ev.index = idx;
      ev.action = act;
      ev.keycode = kc;
      return ev;
   endfunction

   // mostly press, release and tap, now and then an action the queue ignores
   function automatic event_type random_event();
      int        pick;
      logic [7:0] act;
      pick = $urandom_range(0, 9);
      if (pick < 3) act = ACT_PRESS;
      else if (pick < 6) act = ACT_RELEASE;
      else if (pick < 9) act = ACT_TAP;
      else act = 8'($urandom_range(3, 255));
      return make_event(8'($urandom_range(0, 255)), act, 16'($urandom_range(0, 65535)));
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // called at a falling edge; returns at a falling edge after the gap
   task automatic send_transaction(input cmd_kind_type kind, input event_type ev,
                                   input int gap);
      req_op <= kind;
      req_index <= ev.index;
      req_action <= ev.action;
      req_keycode <= ev.keycode;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_transaction(kind, ev);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic push_event(input event_type ev);
      send_transaction(CMD_PUSH, ev, draw_gap());
   endtask

   task automatic drain_queue();
      // fields are don't-care on a drain, so they carry noise
      send_transaction(CMD_DRAIN, random_event(), draw_gap());
   endtask

   initial begin
      int burst;
      no_idle = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty drain, field extremes, tap release, full ring overflow
      drain_queue();
      push_event(make_event(8'h00, ACT_PRESS, 16'h0000));
      push_event(make_event(8'hff, ACT_RELEASE, 16'hffff));
      push_event(make_event(8'h5a, ACT_TAP, 16'ha5c3));
      drain_queue();
      drain_queue();
      push_event(make_event(8'h11, ACT_PRESS, 16'h1111));
      push_event(make_event(8'h22, ACT_TAP, 16'h2222));
      push_event(make_event(8'h33, ACT_RELEASE, 16'h3333));
      push_event(make_event(8'haa, 8'hff, 16'h5555));
      repeat (QUEUE_DEPTH - 4) push_event(random_event());
      // overflow drops a press, a tap and a release in turn
      repeat (3) push_event(random_event());
      drain_queue();

      // random bursts of pushes closed by a drain, with stray drains as noise
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 6)
                                             : $urandom_range(0, 8);
         for (int i = 0; i < burst; i++) begin
            if ($urandom_range(0, 19) == 0) drain_queue();
            else push_event(random_event());
            items_sent++;
         end
         drain_queue();
         items_sent++;
      end
      drain_queue();
      drain_queue();
      start <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (QUEUE_DEPTH + 16) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/dkeq_pkg.sv
design/dkeq_ram.sv
design/dkeq_front.sv
design/dkeq_back.sv
design/deferred_key_event_queue_core.sv
design/dkeq_checker.sv
tb/testbench.sv
